FILE: design/addressed_frame_occupancy_counter_top_macros.svh
// Assertion macros for the addressed frame occupancy counter.
`ifndef ADDRESSED_FRAME_OCCUPANCY_COUNTER_TOP_MACROS_SVH
`define ADDRESSED_FRAME_OCCUPANCY_COUNTER_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define AFOC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("afoc check failed");

// next-cycle implication, checked out of reset
`define AFOC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("afoc check failed");

`endif

FILE: design/afoc_pkg.sv
// Package: codes, reset values and types for the addressed frame occupancy counter.
`timescale 1ns / 1ps
package afoc_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned CNT_W   = 7;
  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned EV_W    = 3;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CNT_W-1:0] COUNT_TOP = 7'd99;

  // tens digit by reciprocal: (x * 103) >> 10 is exact for x below 100
  localparam int unsigned TENS_MUL   = 103;
  localparam int unsigned TENS_SHIFT = 10;
  localparam int unsigned TENS_PROD_W = 14;

  localparam logic [BYTE_W-1:0] START_ADDR_RST = 8'h44;
  localparam logic [BYTE_W-1:0] END_ADDR_RST   = 8'h55;
  localparam logic [BYTE_W-1:0] ENTER_ADDR_RST = 8'h33;
  localparam logic [BYTE_W-1:0] LEAVE_ADDR_RST = 8'h22;
  localparam logic [BYTE_W-1:0] CMD_ON_RST     = 8'h11;

  typedef enum logic [CMD_W-1:0] {
    CMD_BYTE  = 2'd0,
    CMD_START = 2'd1,
    CMD_END   = 2'd2,
    CMD_SPARE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    POS_ADDR  = 2'd0,
    POS_DATA  = 2'd1,
    POS_CHECK = 2'd2
  } pos_t;

  typedef enum logic [EV_W-1:0] {
    EV_INCOMPLETE = 3'd0,
    EV_BAD_CHECK  = 3'd1,
    EV_START      = 3'd2,
    EV_END        = 3'd3,
    EV_COUNT      = 3'd4,
    EV_ZERO       = 3'd5,
    EV_STANDBY    = 3'd6,
    EV_NONE       = 3'd7
  } ev_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_ADDR = 3'd0,
    CFG_END_ADDR   = 3'd1,
    CFG_ENTER_ADDR = 3'd2,
    CFG_LEAVE_ADDR = 3'd3,
    CFG_CMD_ON     = 3'd4
  } cfg_idx_t;

endpackage

FILE: design/afoc_in_if.sv
// Input channel interface: command and received byte.
`timescale 1ns / 1ps
interface afoc_in_if;
  logic                            valid;
  logic                            ready;
  logic [afoc_pkg::CMD_W-1:0]      command;
  logic [afoc_pkg::BYTE_W-1:0]     rx_byte;

  modport source (output valid, output command, output rx_byte, input ready);
  modport sink   (input valid, input command, input rx_byte, output ready);
endinterface

FILE: design/afoc_out_if.sv
// Result channel interface: lamps, occupancy digits and event code.
`timescale 1ns / 1ps
interface afoc_out_if;
  logic                            valid;
  logic                            ready;
  logic                            start_lamp;
  logic                            end_lamp;
  logic                            occupied;
  logic [afoc_pkg::DIGIT_W-1:0]    count_ones;
  logic [afoc_pkg::DIGIT_W-1:0]    count_tens;
  logic [afoc_pkg::EV_W-1:0]       event_res;

  modport source (output valid, output start_lamp, output end_lamp, output occupied,
                  output count_ones, output count_tens, output event_res, input ready);
  modport sink   (input valid, input start_lamp, input end_lamp, input occupied,
                  input count_ones, input count_tens, input event_res, output ready);
endinterface

FILE: design/addressed_frame_occupancy_counter_top.sv
// Top level: frame decoder, lamp control and saturating occupancy counter.
//
//   channel  | dir | payload                                    | handshake
//   in_ch    | in  | command, rx_byte                           | valid/ready
//   out_ch   | out | start_lamp, end_lamp, occupied, digits, ev  | valid/ready
//   cfg_*    | in  | cfg_index, cfg_data                        | cfg_we
//
// One word per cycle sustained while out_ch.ready holds; a stalled result holds the flow.
// Input register feeds one pass of compare/count logic into the result register.
// in_ch.ready stays high while the input register can move on; a stalled result
// still leaves room for one more word in the input register.
// Synchronous active-low reset: lamps on, count zero, frame position at address.
`timescale 1ns / 1ps
`include "addressed_frame_occupancy_counter_top_macros.svh"
module addressed_frame_occupancy_counter_top (
  input  logic                                clk,
  input  logic                                rst_n,
  afoc_in_if.sink                             in_ch,
  afoc_out_if.source                          out_ch,
  input  logic                                cfg_we,
  input  logic [afoc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [afoc_pkg::BYTE_W-1:0]         cfg_data
);

  // configuration
  logic [afoc_pkg::BYTE_W-1:0] start_addr_r, end_addr_r, enter_addr_r, leave_addr_r, cmd_on_r;

  // input register
  logic                        s1_valid_r;
  afoc_pkg::cmd_t              s1_cmd_r;
  logic [afoc_pkg::BYTE_W-1:0] s1_byte_r;

  // block state
  afoc_pkg::pos_t              pos_r, pos_nxt;
  logic [afoc_pkg::BYTE_W-1:0] held_addr_r, held_addr_nxt;
  logic [afoc_pkg::BYTE_W-1:0] held_data_r, held_data_nxt;
  logic [afoc_pkg::CNT_W-1:0]  occ_r, occ_nxt;
  logic                        start_lamp_r, start_lamp_nxt;
  logic                        end_lamp_r, end_lamp_nxt;
  afoc_pkg::ev_t               ev_nxt;

  // result register
  logic                          out_valid_r;
  logic                          out_start_r, out_end_r, out_occ_r;
  logic [afoc_pkg::DIGIT_W-1:0]  out_ones_r, out_tens_r;
  afoc_pkg::ev_t                 out_ev_r;

  logic                              advance, in_ready;
  logic [afoc_pkg::BYTE_W:0]         frame_sum;
  logic [afoc_pkg::TENS_PROD_W-1:0]  tens_prod;
  logic [afoc_pkg::DIGIT_W-1:0]      tens_nxt, ones_nxt;
  logic [afoc_pkg::CNT_W-1:0]        tens_x10;

  assign advance  = !out_valid_r || out_ch.ready;
  assign in_ready = !s1_valid_r || advance;
  assign in_ch.ready = in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_addr_r <= afoc_pkg::START_ADDR_RST;
      end_addr_r   <= afoc_pkg::END_ADDR_RST;
      enter_addr_r <= afoc_pkg::ENTER_ADDR_RST;
      leave_addr_r <= afoc_pkg::LEAVE_ADDR_RST;
      cmd_on_r     <= afoc_pkg::CMD_ON_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        afoc_pkg::CFG_START_ADDR: start_addr_r <= cfg_data;
        afoc_pkg::CFG_END_ADDR:   end_addr_r   <= cfg_data;
        afoc_pkg::CFG_ENTER_ADDR: enter_addr_r <= cfg_data;
        afoc_pkg::CFG_LEAVE_ADDR: leave_addr_r <= cfg_data;
        afoc_pkg::CFG_CMD_ON:     cmd_on_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_ch.valid) begin
      s1_cmd_r  <= afoc_pkg::cmd_t'(in_ch.command);
      s1_byte_r <= in_ch.rx_byte;
    end
  end

  assign frame_sum = {1'b0, held_addr_r} + {1'b0, held_data_r};

  always_comb begin
    pos_nxt        = pos_r;
    held_addr_nxt  = held_addr_r;
    held_data_nxt  = held_data_r;
    occ_nxt        = occ_r;
    start_lamp_nxt = start_lamp_r;
    end_lamp_nxt   = end_lamp_r;
    ev_nxt         = afoc_pkg::EV_NONE;
    case (s1_cmd_r)
      afoc_pkg::CMD_BYTE: begin
        case (pos_r)
          afoc_pkg::POS_ADDR: begin
            held_addr_nxt = s1_byte_r;
            pos_nxt       = afoc_pkg::POS_DATA;
            ev_nxt        = afoc_pkg::EV_INCOMPLETE;
          end
          afoc_pkg::POS_DATA: begin
            held_data_nxt = s1_byte_r;
            pos_nxt       = afoc_pkg::POS_CHECK;
            ev_nxt        = afoc_pkg::EV_INCOMPLETE;
          end
          default: begin
            pos_nxt = afoc_pkg::POS_ADDR;
            if ({1'b0, s1_byte_r} != frame_sum) begin
              ev_nxt = afoc_pkg::EV_BAD_CHECK;
            end else if (held_data_r == cmd_on_r) begin
              // matching actions all apply; the last one names the event
              if (held_addr_r == start_addr_r) begin
                start_lamp_nxt = 1'b1;
                ev_nxt         = afoc_pkg::EV_START;
              end
              if (held_addr_r == end_addr_r) begin
                end_lamp_nxt = 1'b1;
                ev_nxt       = afoc_pkg::EV_END;
              end
              if (held_addr_r == enter_addr_r) begin
                if (occ_r < afoc_pkg::COUNT_TOP) begin
                  occ_nxt = occ_r + afoc_pkg::CNT_W'(1);
                end
                ev_nxt = afoc_pkg::EV_COUNT;
              end
              if (held_addr_r == leave_addr_r) begin
                if (occ_nxt != '0) begin
                  occ_nxt = occ_nxt - afoc_pkg::CNT_W'(1);
                  ev_nxt  = afoc_pkg::EV_COUNT;
                end else begin
                  ev_nxt = afoc_pkg::EV_ZERO;
                end
              end
            end
          end
        endcase
      end
      afoc_pkg::CMD_START: begin
        start_lamp_nxt = !start_lamp_r;
        ev_nxt = start_lamp_nxt ? afoc_pkg::EV_START : afoc_pkg::EV_STANDBY;
      end
      afoc_pkg::CMD_END: begin
        end_lamp_nxt = !end_lamp_r;
        ev_nxt = end_lamp_nxt ? afoc_pkg::EV_END : afoc_pkg::EV_STANDBY;
      end
      default: ;
    endcase
  end

  assign tens_prod = afoc_pkg::TENS_PROD_W'(occ_nxt) * afoc_pkg::TENS_PROD_W'(afoc_pkg::TENS_MUL);
  assign tens_nxt  = tens_prod[afoc_pkg::TENS_SHIFT +: afoc_pkg::DIGIT_W];
  assign tens_x10  = afoc_pkg::CNT_W'({tens_nxt, 3'b000}) + afoc_pkg::CNT_W'({tens_nxt, 1'b0});
  assign ones_nxt  = afoc_pkg::DIGIT_W'(occ_nxt - tens_x10);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= afoc_pkg::POS_ADDR;
      held_addr_r  <= '0;
      held_data_r  <= '0;
      occ_r        <= '0;
      start_lamp_r <= 1'b1;
      end_lamp_r   <= 1'b1;
      out_valid_r  <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
      if (s1_valid_r) begin
        pos_r        <= pos_nxt;
        held_addr_r  <= held_addr_nxt;
        held_data_r  <= held_data_nxt;
        occ_r        <= occ_nxt;
        start_lamp_r <= start_lamp_nxt;
        end_lamp_r   <= end_lamp_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      out_start_r <= start_lamp_nxt;
      out_end_r   <= end_lamp_nxt;
      out_occ_r   <= (occ_nxt != '0);
      out_ones_r  <= ones_nxt;
      out_tens_r  <= tens_nxt;
      out_ev_r    <= ev_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.start_lamp = out_start_r;
  assign out_ch.end_lamp   = out_end_r;
  assign out_ch.occupied   = out_occ_r;
  assign out_ch.count_ones = out_ones_r;
  assign out_ch.count_tens = out_tens_r;
  assign out_ch.event_res  = out_ev_r;

  `AFOC_ASSERT_NOW(a_count_cap, 1'b1, occ_r <= afoc_pkg::COUNT_TOP)
  `AFOC_ASSERT_NOW(a_pos_legal, 1'b1, pos_r != 2'd3)
  `AFOC_ASSERT_NOW(a_digits_ok, out_valid_r,
    (out_ones_r <= 4'd9) && (out_tens_r <= 4'd9) && (out_occ_r == ((out_ones_r != '0) || (out_tens_r != '0))))
  `AFOC_ASSERT_NEXT(a_frame_wrap,
    advance && s1_valid_r && (s1_cmd_r == afoc_pkg::CMD_BYTE) && (pos_r == afoc_pkg::POS_CHECK),
    pos_r == afoc_pkg::POS_ADDR)
  `AFOC_ASSERT_NEXT(a_stall_holds_state, !advance, $stable(occ_r) && $stable(pos_r))

endmodule

FILE: tb/afoc_panel_checker.sv
// Checker: predicts every result word of the occupancy counter and compares it on arrival.
`timescale 1ns / 1ps
module afoc_panel_checker
  import afoc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  afoc_in_if                   in_mon,
  afoc_out_if                  out_mon,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_data,
  output int unsigned          mismatches,
  output int unsigned          words_due,
  output int unsigned          words_checked
);

  typedef struct packed {
    logic               start_lamp;
    logic               end_lamp;
    logic               occupied;
    logic [DIGIT_W-1:0] count_ones;
    logic [DIGIT_W-1:0] count_tens;
    ev_t                event_res;
  } panel_word_t;

  panel_word_t panel_due[$];

  logic [BYTE_W-1:0] start_addr, end_addr, enter_addr, leave_addr, trigger_data;
  pos_t              frame_pos;
  logic [BYTE_W-1:0] frame_addr, frame_data;
  logic [CNT_W-1:0]  headcount;
  logic              start_on, end_on;

  function automatic panel_word_t advance_panel(cmd_t cmd, logic [BYTE_W-1:0] rx);
    ev_t         ev;
    panel_word_t w;
    logic [BYTE_W:0] frame_sum;
    ev = EV_NONE;
    case (cmd)
      CMD_BYTE: begin
        case (frame_pos)
          POS_ADDR: begin
            frame_addr = rx;
            frame_pos  = POS_DATA;
            ev         = EV_INCOMPLETE;
          end
          POS_DATA: begin
            frame_data = rx;
            frame_pos  = POS_CHECK;
            ev         = EV_INCOMPLETE;
          end
          default: begin
            frame_pos = POS_ADDR;
            frame_sum = {1'b0, frame_addr} + {1'b0, frame_data};
            if ({1'b0, rx} != frame_sum) begin
              ev = EV_BAD_CHECK;
            end else if (frame_data == trigger_data) begin
              // all matching actions apply in turn; the last one names the event
              if (frame_addr == start_addr) begin
                start_on = 1'b1;
                ev       = EV_START;
              end
              if (frame_addr == end_addr) begin
                end_on = 1'b1;
                ev     = EV_END;
              end
              if (frame_addr == enter_addr) begin
                if (headcount < COUNT_TOP) headcount = headcount + 1'b1;
                ev = EV_COUNT;
              end
              if (frame_addr == leave_addr) begin
                if (headcount != '0) begin
                  headcount = headcount - 1'b1;
                  ev        = EV_COUNT;
                end else begin
                  ev = EV_ZERO;
                end
              end
            end
          end
        endcase
      end
      CMD_START: begin
        start_on = !start_on;
        ev       = start_on ? EV_START : EV_STANDBY;
      end
      CMD_END: begin
        end_on = !end_on;
        ev     = end_on ? EV_END : EV_STANDBY;
      end
      default: ;
    endcase
    w.start_lamp = start_on;
    w.end_lamp   = end_on;
    w.occupied   = (headcount != '0);
    w.count_ones = DIGIT_W'(headcount % 7'd10);
    w.count_tens = DIGIT_W'(headcount / 7'd10);
    w.event_res  = ev;
    return w;
  endfunction

  function automatic void note_mismatch(string what, panel_word_t want, panel_word_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t %s: expected lamps %b/%b occ %b count %0d%0d ev %0d, got lamps %b/%b occ %b count %0d%0d ev %0d",
               $time, what, want.start_lamp, want.end_lamp, want.occupied, want.count_tens,
               want.count_ones, want.event_res, got.start_lamp, got.end_lamp, got.occupied,
               got.count_tens, got.count_ones, got.event_res);
  endfunction

  always @(posedge clk) begin
    panel_word_t got;
    panel_word_t want;
    if (!rst_n) begin
      start_addr   = START_ADDR_RST;
      end_addr     = END_ADDR_RST;
      enter_addr   = ENTER_ADDR_RST;
      leave_addr   = LEAVE_ADDR_RST;
      trigger_data = CMD_ON_RST;
      frame_pos    = POS_ADDR;
      frame_addr   = '0;
      frame_data   = '0;
      headcount    = '0;
      start_on     = 1'b1;
      end_on       = 1'b1;
      panel_due.delete();
      words_due    = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.start_lamp, out_mon.end_lamp, out_mon.occupied, out_mon.count_ones,
                out_mon.count_tens, ev_t'(out_mon.event_res)};
        words_checked++;
        if (panel_due.size() == 0) begin
          note_mismatch("unexpected word", got, got);
        end else begin
          want = panel_due.pop_front();
          if (got !== want) note_mismatch("word differs", want, got);
        end
      end
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_START_ADDR: start_addr   = cfg_data;
          CFG_END_ADDR:   end_addr     = cfg_data;
          CFG_ENTER_ADDR: enter_addr   = cfg_data;
          CFG_LEAVE_ADDR: leave_addr   = cfg_data;
          CFG_CMD_ON:     trigger_data = cfg_data;
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready)
        panel_due.push_back(advance_panel(cmd_t'(in_mon.command), in_mon.rx_byte));
      words_due = panel_due.size();
    end
  end

endmodule

FILE: tb/tb.sv
// Testbench top: drives words, register settings and result stalls, and gives the verdict.
`timescale 1ns / 1ps
module tb;
  import afoc_pkg::*;

  typedef enum logic [1:0] {FLOW_OPEN, FLOW_BUSY, FLOW_SPARSE, FLOW_PERIODIC} flow_t;

  localparam cfg_idx_t REG_ORDER [5] = '{CFG_START_ADDR, CFG_END_ADDR, CFG_ENTER_ADDR,
                                         CFG_LEAVE_ADDR, CFG_CMD_ON};

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [BYTE_W-1:0]    cfg_data;
  int unsigned          mismatches, words_due, words_checked;

  logic [BYTE_W-1:0] cur_cfg [5];
  int unsigned       words_sent, settings_used, burst_left, byte_phase, flow_left;
  bit                valid_high;
  flow_t             flow = FLOW_OPEN;

  afoc_in_if  in_ch();
  afoc_out_if out_ch();

  addressed_frame_occupancy_counter_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  afoc_panel_checker panel_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .words_due     (words_due),
    .words_checked (words_checked)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (flow_left == 0) begin
      flow      = flow_t'($urandom_range(0, 3));
      flow_left = $urandom_range(16, 160);
    end else begin
      flow_left--;
    end
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      case (flow)
        FLOW_OPEN:   out_ch.ready <= 1'b1;
        FLOW_BUSY:   out_ch.ready <= ($urandom_range(0, 3) != 0);
        FLOW_SPARSE: out_ch.ready <= ($urandom_range(0, 4) == 0);
        default:     out_ch.ready <= ((flow_left % 7) < 3);
      endcase
    end
  end

  task automatic send_word(input cmd_t cmd, input logic [BYTE_W-1:0] rx);
    if (burst_left == 0) begin
      if (valid_high) begin
        in_ch.valid <= 1'b0;
        valid_high = 1'b0;
      end
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 6);
    end
    in_ch.valid   <= 1'b1;
    in_ch.command <= cmd;
    in_ch.rx_byte <= rx;
    valid_high = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    burst_left--;
    words_sent++;
    if (cmd == CMD_BYTE) byte_phase = (byte_phase + 1) % 3;
  endtask

  task automatic send_frame(input logic [BYTE_W-1:0] addr, data, chk);
    send_word(CMD_BYTE, addr);
    send_word(CMD_BYTE, data);
    send_word(CMD_BYTE, chk);
  endtask

  // hold the sender until every outstanding word is back
  task automatic settle();
    if (valid_high) begin
      in_ch.valid <= 1'b0;
      valid_high = 1'b0;
    end
    burst_left = 0;
    do @(negedge clk); while (words_due != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_settings(input logic [BYTE_W-1:0] s, e, n, l, c);
    settle();
    cur_cfg = '{s, e, n, l, c};
    foreach (REG_ORDER[i]) begin
      cfg_we    <= 1'b1;
      cfg_index <= REG_ORDER[i];
      cfg_data  <= cur_cfg[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // mostly well-formed frames aimed at the programmed addresses, plus presses and noise
  task automatic run_random(input int unsigned count, up_pct, down_pct);
    int unsigned       stop_at;
    int unsigned       roll;
    logic [BYTE_W-1:0] addr, data, chk;
    logic [BYTE_W:0]   total;
    stop_at = words_sent + count;
    while (words_sent < stop_at) begin
      roll = $urandom_range(0, 99);
      if (roll < 75) begin
        while (byte_phase != 0) send_word(CMD_BYTE, BYTE_W'($urandom));
        roll = $urandom_range(0, 99);
        if (roll < up_pct) addr = cur_cfg[2];
        else if (roll < up_pct + down_pct) addr = cur_cfg[3];
        else if (roll < 90) addr = $urandom_range(0, 1) ? cur_cfg[0] : cur_cfg[1];
        else addr = BYTE_W'($urandom);
        data  = ($urandom_range(0, 99) < 85) ? cur_cfg[4] : BYTE_W'($urandom);
        total = {1'b0, addr} + {1'b0, data};
        chk   = (!total[BYTE_W] && $urandom_range(0, 9) != 0) ? total[BYTE_W-1:0]
                                                             : BYTE_W'($urandom);
        send_word(CMD_BYTE, addr);
        if ($urandom_range(0, 9) == 0)
          send_word($urandom_range(0, 1) ? CMD_START : CMD_END, BYTE_W'($urandom));
        send_word(CMD_BYTE, data);
        send_word(CMD_BYTE, chk);
      end else if (roll < 87) begin
        send_word($urandom_range(0, 1) ? CMD_START : CMD_END, BYTE_W'($urandom));
      end else if (roll < 92) begin
        send_word(CMD_SPARE, BYTE_W'($urandom));
      end else begin
        send_word(CMD_BYTE, BYTE_W'($urandom));
      end
    end
  endtask

  initial begin
    logic [BYTE_W-1:0] dup;
    in_ch.valid   <= 1'b0;
    in_ch.command <= CMD_BYTE;
    in_ch.rx_byte <= '0;
    cfg_we        <= 1'b0;
    cfg_index     <= CFG_START_ADDR;
    cfg_data      <= '0;
    rst_n         <= 1'b0;
    cur_cfg = '{START_ADDR_RST, END_ADDR_RST, ENTER_ADDR_RST, LEAVE_ADDR_RST, CMD_ON_RST};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed words on the reset register values
    send_word(CMD_SPARE, 8'hFF);
    send_frame(LEAVE_ADDR_RST, CMD_ON_RST, LEAVE_ADDR_RST + CMD_ON_RST);
    send_word(CMD_BYTE, ENTER_ADDR_RST);
    send_word(CMD_START, 8'h00);
    send_word(CMD_BYTE, CMD_ON_RST);
    send_word(CMD_END, 8'hFF);
    send_word(CMD_BYTE, ENTER_ADDR_RST + CMD_ON_RST);
    send_frame(LEAVE_ADDR_RST, CMD_ON_RST, LEAVE_ADDR_RST + CMD_ON_RST);
    send_frame(START_ADDR_RST, CMD_ON_RST, START_ADDR_RST + CMD_ON_RST);
    send_frame(END_ADDR_RST, CMD_ON_RST, END_ADDR_RST + CMD_ON_RST);
    send_frame(8'hFF, 8'hFF, 8'hFE);
    send_frame(ENTER_ADDR_RST, 8'h00, ENTER_ADDR_RST);
    send_frame(ENTER_ADDR_RST, CMD_ON_RST, ENTER_ADDR_RST + CMD_ON_RST + 8'd1);

    apply_settings(BYTE_W'($urandom_range(0, 127)), BYTE_W'($urandom_range(0, 127)),
                   BYTE_W'($urandom_range(0, 127)), BYTE_W'($urandom_range(0, 127)),
                   BYTE_W'($urandom_range(0, 127)));
    run_random(700, 80, 5);

    apply_settings('0, '0, '0, '0, '0);
    run_random(150, 40, 40);

    apply_settings('1, '1, '1, '1, '1);
    run_random(100, 25, 25);

    apply_settings(BYTE_W'($urandom_range(0, 127)), BYTE_W'($urandom_range(0, 127)),
                   BYTE_W'($urandom_range(0, 127)), BYTE_W'($urandom_range(0, 127)),
                   BYTE_W'($urandom_range(0, 127)));
    run_random(300, 5, 80);
    settle();
    run_random(300, 5, 80);

    // overlapping addresses
    dup = BYTE_W'($urandom_range(0, 127));
    apply_settings(dup, BYTE_W'($urandom_range(0, 127)), dup, BYTE_W'($urandom_range(0, 127)),
                   BYTE_W'($urandom_range(0, 127)));
    run_random(400, 30, 30);

    settle();
    repeat (8) @(posedge clk);
    $display("Sent %0d words across %0d register settings; %0d result words checked, %0d mismatched.",
             words_sent, settings_used, words_checked, mismatches);
    if (mismatches == 0) begin
      $display("PASS addressed_frame_occupancy_counter_top");
    end else begin
      $display("FAIL addressed_frame_occupancy_counter_top");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timed out with %0d words outstanding.", words_due);
    $display("FAIL addressed_frame_occupancy_counter_top");
    $finish;
  end

endmodule

FILE: addressed_frame_occupancy_counter_top.f
+incdir+design
design/afoc_pkg.sv
design/afoc_in_if.sv
design/afoc_out_if.sv
design/addressed_frame_occupancy_counter_top.sv
tb/afoc_panel_checker.sv
tb/tb.sv
